// ----- src/homogeneous_vertex_transform_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the vertex transform core
// Concurrent checks clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_CORE_MACROS_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_CORE_MACROS_SVH

// same-cycle implication
`define HVT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HVT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hvt_pkg.sv -----
// ---------------------------------------------------------------------------
// hvt_pkg
// Shared constants and register codes of the vertex transform core.
// ---------------------------------------------------------------------------
`default_nettype none

package hvt_pkg;

  localparam int FRAC_BITS = 8;                // Q.8 fraction of coords and coefs
  localparam int ONE_Q     = 2 ** FRAC_BITS;   // 1.0
  localparam int NUM_LANES = 4;                // x, y, z, w
  localparam int SLOT_W    = 16;               // coefficient slot in a row register
  localparam int ROW_W     = NUM_LANES * SLOT_W;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0  = 3'd0,
    REG_ROW1  = 3'd1,
    REG_ROW2  = 3'd2,
    REG_ROW3  = 3'd3,
    REG_PERSP = 3'd4
  } cfg_reg_t;

  typedef logic [ROW_W-1:0] row_t;

  // identity matrix
  localparam row_t ROW_RESET [NUM_LANES] = '{
    64'h0000_0000_0000_0100,
    64'h0000_0000_0100_0000,
    64'h0000_0100_0000_0000,
    64'h0100_0000_0000_0000
  };

endpackage

`default_nettype wire

// ----- src/hvt_vertex_if.sv -----
// ---------------------------------------------------------------------------
// hvt_vertex_if
// Valid/ready channel carrying one homogeneous input vertex.
// ---------------------------------------------------------------------------
`default_nettype none

interface hvt_vertex_if #(
  parameter int COORD_WIDTH = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_in;
  logic signed [COORD_WIDTH-1:0] y_in;
  logic signed [COORD_WIDTH-1:0] z_in;
  logic signed [COORD_WIDTH-1:0] w_in;

  modport source (output valid, x_in, y_in, z_in, w_in, input ready);
  modport sink   (input valid, x_in, y_in, z_in, w_in, output ready);
endinterface

`default_nettype wire

// ----- src/hvt_result_if.sv -----
// ---------------------------------------------------------------------------
// hvt_result_if
// Valid/ready channel carrying one transformed vertex and its flags.
// ---------------------------------------------------------------------------
`default_nettype none

interface hvt_result_if #(
  parameter int COORD_WIDTH = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_out;
  logic signed [COORD_WIDTH-1:0] y_out;
  logic signed [COORD_WIDTH-1:0] z_out;
  logic signed [COORD_WIDTH-1:0] w_out;
  logic                          divide_by_zero;
  logic                          saturated;

  modport source (output valid, x_out, y_out, z_out, w_out, divide_by_zero, saturated,
                  input ready);
  modport sink   (input valid, x_out, y_out, z_out, w_out, divide_by_zero, saturated,
                  output ready);
endinterface

`default_nettype wire

// ----- src/hvt_mac_lane.sv -----
// ---------------------------------------------------------------------------
// hvt_mac_lane
// One output column: four products, summed, rounded to Q.8 and clipped.
// ---------------------------------------------------------------------------
`default_nettype none

module hvt_mac_lane #(
  parameter int COORD_WIDTH = 24,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] vin  [hvt_pkg::NUM_LANES],
  input  logic signed [COEF_WIDTH-1:0]  coef [hvt_pkg::NUM_LANES],
  output logic signed [COORD_WIDTH-1:0] res,
  output logic                          sat
);
  import hvt_pkg::*;

  localparam int PW  = COORD_WIDTH + COEF_WIDTH;   // one product
  localparam int SW  = PW + 2;                     // sum of four
  localparam int SHW = SW - FRAC_BITS;             // after dropping the fraction

  localparam logic signed [SW-1:0]  HALF    = SW'(2 ** (FRAC_BITS - 1));
  localparam logic signed [SHW-1:0] CLIP_HI = SHW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [SHW-1:0] CLIP_LO = -CLIP_HI - SHW'(1);

  logic signed [PW-1:0]  prod [NUM_LANES];
  logic signed [SW-1:0]  pair [2];
  logic signed [SW-1:0]  acc;
  logic signed [SHW-1:0] shifted;

  always_comb begin
    acc     = pair[0] + pair[1] + HALF;
    shifted = SHW'(acc >>> FRAC_BITS);   // arithmetic shift floors
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        prod[k] <= PW'(vin[k]) * PW'(coef[k]);
      end
      pair[0] <= SW'(prod[0]) + SW'(prod[1]);
      pair[1] <= SW'(prod[2]) + SW'(prod[3]);
      if (shifted > CLIP_HI) begin
        res <= COORD_WIDTH'(CLIP_HI);
        sat <= 1'b1;
      end else if (shifted < CLIP_LO) begin
        res <= COORD_WIDTH'(CLIP_LO);
        sat <= 1'b1;
      end else begin
        res <= COORD_WIDTH'(shifted);
        sat <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/hvt_div_lane.sv -----
// ---------------------------------------------------------------------------
// hvt_div_lane
// Pipelined restoring divider, one quotient bit per stage: (num*256)/den,
// rounded to nearest with ties away from zero, then clipped.
// ---------------------------------------------------------------------------
`default_nettype none

module hvt_div_lane #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] num,
  input  logic signed [COORD_WIDTH-1:0] den,
  output logic signed [COORD_WIDTH-1:0] quot,
  output logic                          sat
);
  import hvt_pkg::*;

  // dividend 2*|num|*256 + |den|, divisor 2*|den|
  localparam int NW = COORD_WIDTH + FRAC_BITS + 1;
  localparam int DW = COORD_WIDTH + 1;

  localparam logic signed [NW:0] CLIP_HI = (NW+1)'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [NW:0] CLIP_LO = -CLIP_HI - (NW+1)'(1);

  logic [COORD_WIDTH-1:0] mag_n;
  logic [COORD_WIDTH-1:0] mag_d;

  logic [NW-1:0] nq   [NW+1];   // dividend bits out, quotient bits in
  logic [DW-1:0] rem  [NW+1];
  logic [DW-1:0] dd   [NW+1];
  logic          neg  [NW+1];
  logic [DW:0]   trial [NW];
  logic [DW:0]   diff  [NW];
  logic signed [NW:0] qs;

  always_comb begin
    mag_n = num[COORD_WIDTH-1] ? $unsigned(-num) : $unsigned(num);
    mag_d = den[COORD_WIDTH-1] ? $unsigned(-den) : $unsigned(den);
    for (int i = 0; i < NW; i++) begin
      trial[i] = {rem[i], nq[i][NW-1]};
      diff[i]  = trial[i] - {1'b0, dd[i]};
    end
    qs = $signed({1'b0, nq[NW]});
    if (neg[NW]) begin
      qs = -qs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nq[0]  <= (NW'(mag_n) << (FRAC_BITS + 1)) + NW'(mag_d);
      rem[0] <= '0;
      dd[0]  <= DW'(mag_d) << 1;
      neg[0] <= num[COORD_WIDTH-1] ^ den[COORD_WIDTH-1];
      for (int i = 0; i < NW; i++) begin
        if (!diff[i][DW]) begin
          rem[i+1] <= diff[i][DW-1:0];
          nq[i+1]  <= {nq[i][NW-2:0], 1'b1};
        end else begin
          rem[i+1] <= trial[i][DW-1:0];
          nq[i+1]  <= {nq[i][NW-2:0], 1'b0};
        end
        dd[i+1]  <= dd[i];
        neg[i+1] <= neg[i];
      end
      if (qs > CLIP_HI) begin
        quot <= COORD_WIDTH'(CLIP_HI);
        sat  <= 1'b1;
      end else if (qs < CLIP_LO) begin
        quot <= COORD_WIDTH'(CLIP_LO);
        sat  <= 1'b1;
      end else begin
        quot <= COORD_WIDTH'(qs);
        sat  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/homogeneous_vertex_transform_core.sv -----
// ---------------------------------------------------------------------------
// homogeneous_vertex_transform_core
// 4x4 matrix transform of Q16.8 vertices with optional perspective divide.
// ---------------------------------------------------------------------------
// Takes one vertex per clock and returns one result per clock, in order,
// while the output is not held off. The four column lanes load their
// products at the transfer edge, then register the pair sums and then the
// rounded and clipped result; the divider pipes follow with a prep stage,
// the bit stages (one quotient bit per stage, which sets the depth) and a
// clip stage, and the merge feeds the output register. The whole pipe moves
// in lockstep; a two-entry output buffer (output register plus skid) lets
// one more result in while a result waits, and input ready is simply "skid
// empty". The divide latency is paid in both modes. Matrix rows and the
// perspective bit are plain registers written through cfg_we/cfg_index/
// cfg_data and are read live, so change them only with the pipe empty.
// ---------------------------------------------------------------------------
`default_nettype none

module homogeneous_vertex_transform_core #(
  parameter int COORD_WIDTH = 24,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hvt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hvt_pkg::ROW_W-1:0]       cfg_data,
  hvt_vertex_if.sink                      vertex,
  hvt_result_if.source                    result
);
  import hvt_pkg::*;

`include "homogeneous_vertex_transform_core_macros.svh"

  localparam int MAC_LAT = 3;
  localparam int DIV_LAT = COORD_WIDTH + FRAC_BITS + 3;   // prep + bit stages + clip
  localparam int L       = MAC_LAT + DIV_LAT;
  localparam int NDIV    = NUM_LANES - 1;                 // x, y, z get divided

  // ---- configuration registers ----
  row_t rows [NUM_LANES];
  logic persp;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows  <= ROW_RESET;
      persp <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW0:  rows[0] <= cfg_data;
        REG_ROW1:  rows[1] <= cfg_data;
        REG_ROW2:  rows[2] <= cfg_data;
        REG_ROW3:  rows[3] <= cfg_data;
        REG_PERSP: persp   <= cfg_data[0];
        default:   ;   // unknown index: ignored
      endcase
    end
  end

  // ---- pipe control ----
  logic         en;            // whole pipe advances
  logic [L-1:0] vld;
  logic         out_valid;
  logic         skid_valid;

  assign en           = !skid_valid;
  assign vertex.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], vertex.valid};
    end
  end

  // ---- column lanes: coef[j][k] = M[k][j] ----
  logic signed [COORD_WIDTH-1:0] vin  [NUM_LANES];
  logic signed [COEF_WIDTH-1:0]  coef [NUM_LANES][NUM_LANES];
  logic signed [COORD_WIDTH-1:0] mres [NUM_LANES];
  logic                          msat [NUM_LANES];

  assign vin[0] = vertex.x_in;
  assign vin[1] = vertex.y_in;
  assign vin[2] = vertex.z_in;
  assign vin[3] = vertex.w_in;

  always_comb begin
    for (int j = 0; j < NUM_LANES; j++) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        coef[j][k] = rows[k][SLOT_W*j +: COEF_WIDTH];
      end
    end
  end

  for (genvar j = 0; j < NUM_LANES; j++) begin : g_mac
    hvt_mac_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
    ) u_mac (
      .clk  (clk),
      .en   (en),
      .vin  (vin),
      .coef (coef[j]),
      .res  (mres[j]),
      .sat  (msat[j])
    );
  end

  // ---- divider lanes, all divided by transformed w ----
  logic signed [COORD_WIDTH-1:0] dq   [NDIV];
  logic                          dsat [NDIV];

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    hvt_div_lane #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_div (
      .clk  (clk),
      .en   (en),
      .num  (mres[j]),
      .den  (mres[NUM_LANES-1]),
      .quot (dq[j]),
      .sat  (dsat[j])
    );
  end

  // ---- side line: undivided results travel alongside the dividers ----
  logic signed [COORD_WIDTH-1:0] side_r   [DIV_LAT][NUM_LANES];
  logic                          side_sat [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0]   <= mres;
      side_sat[0] <= msat[0] | msat[1] | msat[2] | msat[3];
      for (int i = 1; i < DIV_LAT; i++) begin
        side_r[i]   <= side_r[i-1];
        side_sat[i] <= side_sat[i-1];
      end
    end
  end

  // ---- merge ----
  logic signed [COORD_WIDTH-1:0] m_r [NUM_LANES];
  logic                          m_dz;
  logic                          m_sat;

  always_comb begin
    m_r   = side_r[DIV_LAT-1];
    m_dz  = 1'b0;
    m_sat = side_sat[DIV_LAT-1];
    if (persp) begin
      if (side_r[DIV_LAT-1][NUM_LANES-1] == '0) begin
        // zero w: everything cleared, clip flag from the multiply only
        for (int j = 0; j < NUM_LANES; j++) begin
          m_r[j] = '0;
        end
        m_dz = 1'b1;
      end else begin
        for (int j = 0; j < NDIV; j++) begin
          m_r[j] = dq[j];
        end
        m_r[NUM_LANES-1] = COORD_WIDTH'(ONE_Q);
        m_sat = side_sat[DIV_LAT-1] | dsat[0] | dsat[1] | dsat[2];
      end
    end
  end

  // ---- output register and skid ----
  logic signed [COORD_WIDTH-1:0] out_r  [NUM_LANES];
  logic                          out_dz;
  logic                          out_sat;
  logic signed [COORD_WIDTH-1:0] skid_r [NUM_LANES];
  logic                          skid_dz;
  logic                          skid_sat;
  logic                          take;
  logic                          push;

  assign take = out_valid && result.ready;
  assign push = en && vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_valid) begin
      out_r   <= skid_r;
      out_dz  <= skid_dz;
      out_sat <= skid_sat;
    end else if ((take || !out_valid) && push) begin
      out_r   <= m_r;
      out_dz  <= m_dz;
      out_sat <= m_sat;
    end else if (push) begin
      skid_r   <= m_r;
      skid_dz  <= m_dz;
      skid_sat <= m_sat;
    end
  end

  assign result.valid          = out_valid;
  assign result.x_out          = out_r[0];
  assign result.y_out          = out_r[1];
  assign result.z_out          = out_r[2];
  assign result.w_out          = out_r[3];
  assign result.divide_by_zero = out_dz;
  assign result.saturated      = out_sat;

  // ---- checks ----
  logic out_zero;

  assign out_zero = (out_r[0] == '0) && (out_r[1] == '0) && (out_r[2] == '0) &&
                    (out_r[3] == '0);

  `HVT_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid, "skid holds data with output empty")
  `HVT_ASSERT_NXT(a_stall_freezes_pipe, !en, $stable(vld), "pipe moved during a stall")
  `HVT_ASSERT_IMP(a_dz_clears, out_valid && out_dz, out_zero, "zero w result not cleared")
  `HVT_ASSERT_NXT(a_drain_empties, take && !skid_valid && !push, !out_valid, "output kept a taken result")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the homogeneous vertex transform core.
// -----------------------------------------------------------------------------
// Vertices go in over the valid/ready input channel. A local predictor keeps
// its own copy of the four matrix rows and the perspective bit, and works out
// each transformed vertex at the moment of the input transfer. Results are
// checked in order, field by field, as they transfer out. Corner cases come
// first, then randomised phases over several matrix settings, the first four
// idling on both sides, then a long output stall backing up the whole pipe.
// -----------------------------------------------------------------------------

module tb_top;
  import hvt_pkg::*;

  localparam int     COORD_W       = 24;
  localparam int     COEF_W        = 16;
  localparam longint COORD_MAX     = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN     = -(longint'(1) << (COORD_W - 1));
  // input transfer to result
  localparam int     PIPE_LATENCY  = COORD_W + 14;
  localparam int     SETTLE_CYCLES = PIPE_LATENCY + 20;
  localparam int     RANDOM_PHASES = 7;
  localparam int     PHASE_ITEMS   = 190;
  localparam int     BURST_ITEMS   = 60;
  localparam int     STALL_CYCLES  = 400;
  localparam int     MAX_REPORTS   = 100;

  // indexes above the perspective bit decode to nothing
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SPARE = CFG_IDX_W'(int'(REG_PERSP) + 1);
  localparam int                   REG_LAST_SPARE  = (1 << CFG_IDX_W) - 1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t w;
  } vertex_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t w;
    logic   div_zero;
    logic   clipped;
  } xformed_t;

  typedef enum int {MAT_IDENTITY, MAT_FULL, MAT_GENTLE, MAT_EXTREME} matrix_kind_t;

  localparam longint EDGE_COORDS [7] = '{COORD_MAX, COORD_MIN, 0, -1, 1, ONE_Q, -ONE_Q};
  localparam int     EXTREME_COEFS [5] = '{32'h7FFF, 32'h8000, 0, 32'hFFFF, ONE_Q};

  // matrix style and perspective bit of each random phase
  localparam matrix_kind_t PHASE_KIND [RANDOM_PHASES] = '{
    MAT_FULL, MAT_GENTLE, MAT_EXTREME, MAT_FULL, MAT_GENTLE, MAT_EXTREME, MAT_IDENTITY
  };
  localparam bit PHASE_PERSP [RANDOM_PHASES] = '{0, 1, 0, 1, 1, 1, 1};

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  row_t                 cfg_data;

  hvt_vertex_if #(.COORD_WIDTH(COORD_W)) vertex_ch ();
  hvt_result_if #(.COORD_WIDTH(COORD_W)) result_ch ();

  homogeneous_vertex_transform_core #(
    .COORD_WIDTH(COORD_W),
    .COEF_WIDTH (COEF_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .vertex   (vertex_ch),
    .result   (result_ch)
  );

  // predictor copy of the register file, reset to the identity matrix
  row_t     coef_rows [NUM_LANES] = ROW_RESET;
  logic     persp_on = 1'b0;

  // transformed vertices still owed by the core, oldest first
  xformed_t owed_vertices [$];

  int mismatches      = 0;
  int vertices_in     = 0;
  int results_checked = 0;
  int divides_done    = 0;
  int zero_w_seen     = 0;
  int clipped_seen    = 0;
  int reg_writes      = 0;

  // idling controls, percent of cycles; stall_left holds the output off
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int stall_left        = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint clamp_coord(input longint val);
    if (val > COORD_MAX) return COORD_MAX;
    if (val < COORD_MIN) return COORD_MIN;
    return val;
  endfunction

  // quotient rounded to nearest, halves away from zero
  function automatic longint div_nearest(input longint num, input longint den);
    logic   neg;
    longint n;
    longint d;
    longint q;
    neg = (num < 0) != (den < 0);
    n   = (num < 0) ? -num : num;
    d   = (den < 0) ? -den : den;
    q   = (2 * n + d) / (2 * d);
    return neg ? -q : q;
  endfunction

  function automatic xformed_t transform_vertex(input vertex_t v);
    longint   lane_in  [NUM_LANES];
    longint   lane_out [NUM_LANES];
    longint   acc;
    longint   coef;
    longint   rounded;
    xformed_t r;
    lane_in[0] = v.x;
    lane_in[1] = v.y;
    lane_in[2] = v.z;
    lane_in[3] = v.w;
    r.div_zero = 1'b0;
    r.clipped  = 1'b0;
    // row vector times matrix: column j sums row k slot j times lane k
    for (int j = 0; j < NUM_LANES; j++) begin
      acc = 0;
      for (int k = 0; k < NUM_LANES; k++) begin
        coef = $signed(coef_rows[k][SLOT_W*j +: COEF_W]);
        acc += lane_in[k] * coef;
      end
      // Q.16 down to Q.8, half added then floored
      rounded     = (acc + ONE_Q / 2) >>> FRAC_BITS;
      lane_out[j] = clamp_coord(rounded);
      if (lane_out[j] != rounded) r.clipped = 1'b1;
    end
    if (persp_on) begin
      if (lane_out[3] == 0) begin
        r.div_zero = 1'b1;
        for (int j = 0; j < NUM_LANES; j++) lane_out[j] = 0;
      end else begin
        for (int j = 0; j < NUM_LANES - 1; j++) begin
          rounded     = div_nearest(lane_out[j] * ONE_Q, lane_out[3]);
          lane_out[j] = clamp_coord(rounded);
          if (lane_out[j] != rounded) r.clipped = 1'b1;
        end
        lane_out[3] = ONE_Q;
      end
    end
    r.x = coord_t'(lane_out[0]);
    r.y = coord_t'(lane_out[1]);
    r.z = coord_t'(lane_out[2]);
    r.w = coord_t'(lane_out[3]);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // mostly small coordinates, some full width, some at the range edges
  function automatic longint random_coord();
    int unsigned pick;
    longint      val;
    pick = $urandom_range(0, 9);
    if (pick < 4)      val = longint'($urandom_range(0, 8192)) - 4096;
    else if (pick < 7) val = $urandom;
    else if (pick < 8) val = EDGE_COORDS[$urandom_range(0, 6)];
    else               val = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
    return longint'(coord_t'(val));
  endfunction

  function automatic longint random_w();
    return ($urandom_range(0, 9) < 4) ? ONE_Q : random_coord();
  endfunction

  function automatic row_t make_row(input matrix_kind_t kind, input int row);
    row_t r;
    int   tmp;
    r = ROW_RESET[row];
    if (kind != MAT_IDENTITY) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        case (kind)
          MAT_FULL:   tmp = $urandom;
          // near-identity: small terms around 1.0 on the diagonal
          MAT_GENTLE: tmp = int'($urandom_range(0, 1024)) - 512 + ((j == row) ? ONE_Q : 0);
          default:    tmp = EXTREME_COEFS[$urandom_range(0, 4)];
        endcase
        r[SLOT_W*j +: SLOT_W] = tmp[SLOT_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] ERROR %s", $time, msg);
  endtask

  task automatic check_field(input string name, input coord_t got, input coord_t want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0d, expected %0d (result %0d)",
                                name, got, want, results_checked));
  endtask

  // one register write; taken at the rising edge between the two falling ones
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input row_t data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_ROW0:  coef_rows[0] = data;
      REG_ROW1:  coef_rows[1] = data;
      REG_ROW2:  coef_rows[2] = data;
      REG_ROW3:  coef_rows[3] = data;
      REG_PERSP: persp_on     = data[0];
      default:   ;
    endcase
    reg_writes++;
  endtask

  // whole matrix, the perspective bit with junk above it, and a spare index
  task automatic load_config(input matrix_kind_t kind, input logic persp);
    row_t persp_word;
    for (int k = 0; k < NUM_LANES; k++)
      write_register(CFG_IDX_W'(int'(REG_ROW0) + k), make_row(kind, k));
    persp_word    = {$urandom, $urandom};
    persp_word[0] = persp;
    write_register(REG_PERSP, persp_word);
    write_register(CFG_IDX_W'($urandom_range(REG_FIRST_SPARE, REG_LAST_SPARE)),
                   {$urandom, $urandom});
  endtask

  // Offers one vertex, after idle cycles drawn one at a time at the sender
  // idle rate, and holds it until the transfer. Valid is only ever set once
  // per falling edge.
  task automatic send_vertex(input longint x, input longint y, input longint z,
                             input longint w);
    @(negedge clk);
    while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      vertex_ch.valid <= 1'b0;
      @(negedge clk);
    end
    vertex_ch.valid <= 1'b1;
    vertex_ch.x_in  <= coord_t'(x);
    vertex_ch.y_in  <= coord_t'(y);
    vertex_ch.z_in  <= coord_t'(z);
    vertex_ch.w_in  <= coord_t'(w);
    do @(posedge clk); while (!vertex_ch.ready);
  endtask

  task automatic send_random_vertex();
    send_vertex(random_coord(), random_coord(), random_coord(), random_w());
  endtask

  // drop valid and wait for every owed result; the pipe is then empty
  task automatic wait_for_results();
    @(negedge clk);
    vertex_ch.valid <= 1'b0;
    while (owed_vertices.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // reset matrix is the identity, so outputs equal inputs
  task automatic test_identity_corners();
    send_vertex(0, 0, 0, 0);
    send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    send_vertex(1, -1, ONE_Q, -ONE_Q);
    send_vertex(COORD_MAX, COORD_MIN, -1, 0);
    wait_for_results();
  endtask

  // largest, most negative, half and minus one-LSB coefficients on x;
  // an all-ones row and a zero row
  task automatic test_coefficient_corners();
    write_register(REG_ROW0, {16'hFFFF, 16'h0080, 16'h8000, 16'h7FFF});
    write_register(REG_ROW1, '0);
    write_register(REG_ROW2, '1);
    write_register(REG_ROW3, ROW_RESET[3]);
    send_vertex(COORD_MAX, 0, 0, ONE_Q);      // clips high and low
    send_vertex(COORD_MIN, 0, 0, ONE_Q);
    send_vertex(1, 0, 0, 0);                  // half LSB tie rounds up
    send_vertex(-1, 0, 0, 0);                 // negative tie rounds to zero
    send_vertex(3, 5, -7, ONE_Q);
    send_vertex(0, COORD_MAX, COORD_MIN, COORD_MIN);
    wait_for_results();
  endtask

  task automatic test_perspective_corners();
    for (int k = 0; k < NUM_LANES; k++)
      write_register(CFG_IDX_W'(int'(REG_ROW0) + k), ROW_RESET[k]);
    write_register(REG_PERSP, '1);            // junk above bit 0 is ignored
    write_register(REG_FIRST_SPARE, '1);      // no such register
    send_vertex(3 * ONE_Q, -5 * ONE_Q, 7, ONE_Q);
    send_vertex(5, 6, 7, 0);                  // zero w
    send_vertex(100, -200, 300, -ONE_Q);
    send_vertex(COORD_MAX, COORD_MIN, 1, 1);  // quotient clips
    send_vertex(1, -1, 3, 2 * ONE_Q);         // halves round away from zero
    send_vertex(0, 0, 0, COORD_MIN);
    send_vertex(COORD_MIN, COORD_MAX, 0, COORD_MAX);
    wait_for_results();
    // w column of 1/256: small w rounds to zero before the divide
    write_register(REG_ROW3, row_t'(1) << (3 * SLOT_W));
    send_vertex(ONE_Q, ONE_Q, ONE_Q, 100);
    wait_for_results();
    write_register(REG_PERSP, 64'hFFFF_FFFF_FFFF_FFFE);
    send_vertex(5, 5, 5, 0);                  // zero w, no flag with divide off
    wait_for_results();
  endtask

  // Random vertices under a fresh register setting per phase. Idling: sender
  // light and receiver heavy first, then swapped, then none at all.
  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 2) begin
        sender_idle_pct   = 19;
        receiver_idle_pct = 54;
      end else if (p < 4) begin
        sender_idle_pct   = 54;
        receiver_idle_pct = 19;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      load_config(PHASE_KIND[p], PHASE_PERSP[p]);
      repeat (PHASE_ITEMS) send_random_vertex();
      wait_for_results();
    end
  endtask

  // Output held off for a long stretch while vertices keep coming: the pipe
  // and skid fill and input ready must drop. Then a pause until all is back.
  task automatic test_output_stall();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    load_config(MAT_GENTLE, 1'b1);
    stall_left = STALL_CYCLES;
    repeat (BURST_ITEMS) send_random_vertex();
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Input monitor: predicts on every input transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : vertex_capture
    vertex_t v;
    if (!rst && vertex_ch.valid && vertex_ch.ready) begin
      v.x = vertex_ch.x_in;
      v.y = vertex_ch.y_in;
      v.z = vertex_ch.z_in;
      v.w = vertex_ch.w_in;
      owed_vertices.push_back(transform_vertex(v));
      vertices_in++;
      if (persp_on) divides_done++;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each output transfer against the oldest owed result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    xformed_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (owed_vertices.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: x_out %0d w_out %0d",
                                  result_ch.x_out, result_ch.w_out));
      end else begin
        want = owed_vertices.pop_front();
        check_field("x_out", result_ch.x_out, want.x);
        check_field("y_out", result_ch.y_out, want.y);
        check_field("z_out", result_ch.z_out, want.z);
        check_field("w_out", result_ch.w_out, want.w);
        check_field("divide_by_zero", coord_t'(result_ch.divide_by_zero),
                    coord_t'(want.div_zero));
        check_field("saturated", coord_t'(result_ch.saturated), coord_t'(want.clipped));
        results_checked++;
        if (want.div_zero) zero_w_seen++;
        if (want.clipped) clipped_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: random hold-offs, or a counted stall when one is asked for
  // ---------------------------------------------------------------------------
  initial begin : result_ready_drive
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_ROW0;
    cfg_data        = '0;
    vertex_ch.valid = 1'b0;
    vertex_ch.x_in  = '0;
    vertex_ch.y_in  = '0;
    vertex_ch.z_in  = '0;
    vertex_ch.w_in  = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_identity_corners();
    test_coefficient_corners();
    test_perspective_corners();
    test_random_phases();
    test_output_stall();

    // nothing owed; give a stray late result time to show up
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d vertices and %0d results across %0d register writes,",
             vertices_in, results_checked, reg_writes);
    $display("%0d through the divide, %0d with zero w, %0d clipped, one long output stall.",
             divides_done, zero_w_seen, clipped_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard, many times the slowest legal run
  initial begin : run_limit
    #2_000_000;
    $display("Run limit reached with %0d results still owed", owed_vertices.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
